@@ rtl/core/sliding_window_sender_engine_core_defines.svh @@
// ----------------------------------------------------------------------------
// Sliding window sender engine: assertion macros
// Shared check macros; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_SENDER_ENGINE_CORE_DEFINES_SVH
`define SLIDING_WINDOW_SENDER_ENGINE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// condition must hold at every sampled edge
`define SWSE_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("swse check failed");
// antecedent implies consequent in the next cycle
`define SWSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swse check failed");
`else
`define SWSE_ASSERT(lbl, cond)
`define SWSE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/swse_pkg.sv @@
// ----------------------------------------------------------------------------
// swse_pkg
// Types, codes and reset constants of the sliding window sender engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swse_pkg;

  localparam int WINDOW_DEPTH_DEF = 64;
  localparam int SLOT_MAX_W       = 12;   // enough for the largest window depth
  localparam int QDEPTH           = 4;
  localparam int QPTR_W           = 2;

  localparam logic [31:0] START_SEQ_DEF  = 32'd0;
  localparam logic [23:0] INIT_RTT_DEF   = 24'd100000;
  localparam logic [19:0] INIT_RWIN_DEF  = 20'd64;
  localparam logic [7:0]  MAX_RETRY_DEF  = 8'd50;

  localparam logic [31:0] MIN_DEV_US = 32'd10000;
  localparam logic [31:0] MIN_RTO_US = 32'd1000000;
  localparam logic [7:0]  FAST_COUNT = 8'd4;

  localparam logic [1:0] MODE_QUEUE = 2'd0;
  localparam logic [1:0] MODE_ACK   = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  localparam logic [1:0] REG_START_SEQ = 2'd0;
  localparam logic [1:0] REG_INIT_RTT  = 2'd1;
  localparam logic [1:0] REG_INIT_RWIN = 2'd2;
  localparam logic [1:0] REG_MAX_RETRY = 2'd3;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_REFUSE  = 3'd1,
    ACT_SEND    = 3'd2,
    ACT_TIMEOUT = 3'd3,
    ACT_FAST    = 3'd4,
    ACT_FAIL    = 3'd5
  } action_t;

  // one queued event, slots of the ack precomputed by the front end
  typedef struct packed {
    logic [1:0]            mode;
    logic [31:0]           now_us;
    logic [31:0]           ack_seq;
    logic [19:0]           recv_window;
    logic [SLOT_MAX_W-1:0] slot_ack;
    logic [SLOT_MAX_W-1:0] slot_ackm1;
  } q_item_t;

  // per-slot bookkeeping
  typedef struct packed {
    logic       retx;
    logic       fast;
    logic [7:0] retry;
  } slot_rec_t;

  typedef struct packed {
    logic        reload;
    logic [31:0] start_seq;
    logic [23:0] init_rtt;
    logic [19:0] init_rwin;
  } cfg_load_t;

endpackage

@@ rtl/core/swse_front.sv @@
// ----------------------------------------------------------------------------
// swse_front
// Accepts events, computes their ack slots and queues them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_window_sender_engine_core_defines.svh"

module swse_front #(
  parameter int WINDOW_DEPTH = swse_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          in_tuser,   // mode
  input  logic [87:0]         in_tdata,   // now_us, ack_seq, recv_window
  output logic                q_valid,
  output swse_pkg::q_item_t   q_item,
  input  logic                q_pop
);

  swse_pkg::q_item_t                 fifo_r [swse_pkg::QDEPTH];
  logic [swse_pkg::QPTR_W-1:0]       wp_r, rp_r;
  logic [swse_pkg::QPTR_W:0]         cnt_r;
  logic                              push;
  swse_pkg::q_item_t                 item;
  logic [31:0]                       ack_m1;

  assign in_tready = (cnt_r != (swse_pkg::QPTR_W+1)'(swse_pkg::QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_item    = fifo_r[rp_r];

  always_comb begin
    ack_m1           = in_tdata[63:32] - 32'd1;
    item.mode        = in_tuser;
    item.now_us      = in_tdata[31:0];
    item.ack_seq     = in_tdata[63:32];
    item.recv_window = in_tdata[83:64];
    item.slot_ack    = swse_pkg::SLOT_MAX_W'(in_tdata[63:32] % WINDOW_DEPTH);
    item.slot_ackm1  = swse_pkg::SLOT_MAX_W'(ack_m1 % WINDOW_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `SWSE_ASSERT(a_q_bound, cnt_r <= (swse_pkg::QPTR_W+1)'(swse_pkg::QDEPTH))

endmodule

@@ rtl/core/swse_back.sv @@
// ----------------------------------------------------------------------------
// swse_back
// Executes one event per unstalled cycle against window, timer and RTT state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_window_sender_engine_core_defines.svh"

module swse_back #(
  parameter int WINDOW_DEPTH = swse_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swse_pkg::cfg_load_t  cfg,
  input  logic [7:0]           max_retries,
  input  logic                 q_valid,
  input  swse_pkg::q_item_t    q_item,
  output logic                 q_pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [2:0]           out_tuser,  // action
  output logic [103:0]         out_tdata   // seq, slot, send_base, timeout_us
);

  localparam int SW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  // execute stage
  logic               e_vld_r;
  swse_pkg::q_item_t  e_r;
  swse_pkg::q_item_t  nx_item;
  logic               fire, load;

  // sender state
  logic [31:0] base_r, nseq_r, credit_r, est_r, dev_r, rto_r, texp_r;
  logic [31:0] base_nxt, nseq_nxt, credit_nxt, est_nxt, dev_nxt, rto_nxt, texp_nxt;
  logic        failed_r, failed_nxt;
  logic [SW-1:0] bslot_r, nslot_r, bslot_nxt, nslot_nxt;

  // slot memories
  swse_pkg::slot_rec_t rec_mem [WINDOW_DEPTH];
  logic [31:0]         st_mem  [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] rvld_r;
  swse_pkg::slot_rec_t rec_p_q, rec_q_q;
  logic [31:0]         st_q;
  logic                rec_we, st_we;
  logic [SW-1:0]       rec_wa, st_wa;
  swse_pkg::slot_rec_t rec_wd;
  logic                lw_rec_en_r, lw_st_en_r;
  logic [SW-1:0]       lw_rec_a_r, lw_st_a_r;
  swse_pkg::slot_rec_t lw_rec_d_r;
  logic [31:0]         lw_st_d_r;
  logic [SW-1:0]       rd_p, rd_q, rd_s;
  logic [SW-1:0]       e_sack, e_sackm1;
  swse_pkg::slot_rec_t rec_p, rec_q, rec_b;
  logic [31:0]         st_v;

  // reload sources
  logic [31:0] ld_start;
  logic [23:0] ld_rtt;
  logic [19:0] ld_rwin;
  logic [24:0] ld_t2;
  logic [31:0] ld_rto, ld_credit;
  logic [SW-1:0] ld_slot;

  // exec
  swse_pkg::action_t act;
  logic [31:0] seq_o;
  logic [SW-1:0] slot_o;
  logic        outst, dup, advv, trig;
  logic [31:0] d_cred, d_tick, cand, cand_d;
  logic [31:0] smp_d, sample, est_u, diff_u, dev_u, rto_u, dev_max;
  logic [34:0] est_sum, dev_sum, rto_sum;

  // output register
  logic               out_vld_r;
  swse_pkg::action_t  o_act_r;
  logic [31:0]        o_seq_r, o_base_r, o_rto_r;
  logic [5:0]         o_slot_r;

  assign fire    = e_vld_r && (!out_vld_r || out_tready);
  assign load    = q_valid && (!e_vld_r || fire);
  assign q_pop   = load;
  assign nx_item = load ? q_item : e_r;
  assign e_sack   = e_r.slot_ack[SW-1:0];
  assign e_sackm1 = e_r.slot_ackm1[SW-1:0];

  // reads are issued for the item that executes next cycle, against next-cycle state
  assign rd_p = bslot_nxt;
  assign rd_q = nx_item.slot_ack[SW-1:0];
  assign rd_s = nx_item.slot_ackm1[SW-1:0];

  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    rec_p_q <= rec_mem[rd_p];
    rec_q_q <= rec_mem[rd_q];
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= e_r.now_us;
    st_q <= st_mem[rd_s];
  end

  // the write of the previous cycle is not in the registered read data
  always_comb begin
    if (lw_rec_en_r && lw_rec_a_r == bslot_r) rec_p = lw_rec_d_r;
    else if (rvld_r[bslot_r])                 rec_p = rec_p_q;
    else                                      rec_p = '0;
    if (lw_rec_en_r && lw_rec_a_r == e_sack)  rec_q = lw_rec_d_r;
    else if (rvld_r[e_sack])                  rec_q = rec_q_q;
    else                                      rec_q = '0;
    st_v = (lw_st_en_r && lw_st_a_r == e_sackm1) ? lw_st_d_r : st_q;
  end

  // RTT, deviation and timeout update
  always_comb begin
    smp_d   = e_r.now_us - st_v;
    sample  = smp_d[31] ? 32'd0 : smp_d;
    est_sum = ({3'b0, est_r} << 3) - {3'b0, est_r} + {3'b0, sample};
    est_u   = est_sum[34:3];
    diff_u  = (sample > est_u) ? (sample - est_u) : (est_u - sample);
    dev_sum = ({3'b0, dev_r} << 1) + {3'b0, dev_r} + {3'b0, diff_u};
    dev_u   = dev_sum[33:2];
    dev_max = (dev_u > swse_pkg::MIN_DEV_US) ? dev_u : swse_pkg::MIN_DEV_US;
    rto_sum = {3'b0, est_u} + {1'b0, dev_max, 2'b00};
    rto_u   = (rto_sum[34:32] != 3'd0) ? 32'hFFFF_FFFF : rto_sum[31:0];
  end

  always_comb begin
    outst      = (base_r != nseq_r);
    act        = swse_pkg::ACT_NONE;
    seq_o      = '0;
    slot_o     = '0;
    base_nxt   = base_r;
    nseq_nxt   = nseq_r;
    credit_nxt = credit_r;
    est_nxt    = est_r;
    dev_nxt    = dev_r;
    rto_nxt    = rto_r;
    texp_nxt   = texp_r;
    failed_nxt = failed_r;
    bslot_nxt  = bslot_r;
    nslot_nxt  = nslot_r;
    rec_we     = 1'b0;
    rec_wa     = nslot_r;
    rec_wd     = '0;
    st_we      = 1'b0;
    st_wa      = nslot_r;
    dup        = 1'b0;
    advv       = 1'b0;
    trig       = 1'b0;
    rec_b      = rec_p;
    d_cred     = credit_r - nseq_r;
    d_tick     = e_r.now_us - texp_r;
    cand       = '0;
    cand_d     = '0;
    if (failed_r) begin
      act = swse_pkg::ACT_FAIL;
    end else begin
      case (e_r.mode)
        swse_pkg::MODE_QUEUE: begin
          if (d_cred != 32'd0 && !d_cred[31]) begin
            rec_we = 1'b1;
            st_we  = 1'b1;
            if (!outst) texp_nxt = e_r.now_us + rto_r;
            act       = swse_pkg::ACT_SEND;
            seq_o     = nseq_r;
            slot_o    = nslot_r;
            nseq_nxt  = nseq_r + 32'd1;
            nslot_nxt = (nslot_r == SW'(WINDOW_DEPTH-1)) ? '0 : nslot_r + 1'b1;
          end else begin
            act = swse_pkg::ACT_REFUSE;
          end
        end
        swse_pkg::MODE_ACK: begin
          dup  = (e_r.ack_seq == base_r);
          advv = !dup && ((e_r.ack_seq - base_r) <= (nseq_r - base_r));
          if (dup) begin
            if (outst && rec_p.retry != 8'hFF) rec_b.retry = rec_p.retry + 8'd1;
          end else if (advv) begin
            if (!rec_p.retx) begin
              est_nxt = est_u;
              dev_nxt = dev_u;
              rto_nxt = rto_u;
            end
            texp_nxt  = e_r.now_us + rto_nxt;
            base_nxt  = e_r.ack_seq;
            bslot_nxt = e_sack;
            rec_b     = rec_q;
          end
          cand   = base_nxt + ((e_r.recv_window < 20'(WINDOW_DEPTH)) ?
                               32'(e_r.recv_window) : 32'(WINDOW_DEPTH));
          cand_d = cand - credit_r;
          if (cand_d != 32'd0 && !cand_d[31]) credit_nxt = cand;
          if (base_nxt != nseq_r && rec_b.retry == swse_pkg::FAST_COUNT && !rec_b.fast) begin
            trig       = 1'b1;
            rec_b.retx = 1'b1;
            rec_b.fast = 1'b1;
            texp_nxt   = e_r.now_us + rto_nxt;
            st_we      = 1'b1;
            st_wa      = bslot_nxt;
            act        = swse_pkg::ACT_FAST;
            seq_o      = base_nxt;
            slot_o     = bslot_nxt;
          end
          rec_we = dup || trig;
          rec_wa = bslot_nxt;
          rec_wd = rec_b;
        end
        swse_pkg::MODE_TICK: begin
          if (outst && !d_tick[31]) begin
            if (rec_p.retry >= max_retries) begin
              failed_nxt = 1'b1;
              act        = swse_pkg::ACT_FAIL;
            end else begin
              rec_we       = 1'b1;
              rec_wa       = bslot_r;
              rec_wd.retx  = 1'b1;
              rec_wd.fast  = 1'b0;
              rec_wd.retry = (rec_p.retry != 8'hFF) ? rec_p.retry + 8'd1 : rec_p.retry;
              st_we        = 1'b1;
              st_wa        = bslot_r;
              texp_nxt     = e_r.now_us + rto_r;
              act          = swse_pkg::ACT_TIMEOUT;
              seq_o        = base_r;
              slot_o       = bslot_r;
            end
          end
        end
        default: ;
      endcase
    end
    if (!fire) begin
      rec_we    = 1'b0;
      st_we     = 1'b0;
      bslot_nxt = bslot_r;
    end
  end

  // load values: package defaults under reset, else the new register values
  always_comb begin
    ld_start  = rst_n ? cfg.start_seq : swse_pkg::START_SEQ_DEF;
    ld_rtt    = rst_n ? cfg.init_rtt  : swse_pkg::INIT_RTT_DEF;
    ld_rwin   = rst_n ? cfg.init_rwin : swse_pkg::INIT_RWIN_DEF;
    ld_t2     = {ld_rtt, 1'b0};
    ld_rto    = (32'(ld_t2) > swse_pkg::MIN_RTO_US) ? 32'(ld_t2) : swse_pkg::MIN_RTO_US;
    ld_credit = ld_start + ((ld_rwin < 20'(WINDOW_DEPTH)) ?
                            32'(ld_rwin) : 32'(WINDOW_DEPTH));
    ld_slot   = SW'(ld_start % WINDOW_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg.reload) begin
      base_r      <= ld_start;
      nseq_r      <= ld_start;
      credit_r    <= ld_credit;
      est_r       <= 32'(ld_rtt);
      dev_r       <= '0;
      rto_r       <= ld_rto;
      texp_r      <= '0;
      failed_r    <= 1'b0;
      bslot_r     <= ld_slot;
      nslot_r     <= ld_slot;
      rvld_r      <= '0;
      lw_rec_en_r <= 1'b0;
      lw_st_en_r  <= 1'b0;
    end else begin
      if (fire) begin
        base_r   <= base_nxt;
        nseq_r   <= nseq_nxt;
        credit_r <= credit_nxt;
        est_r    <= est_nxt;
        dev_r    <= dev_nxt;
        rto_r    <= rto_nxt;
        texp_r   <= texp_nxt;
        failed_r <= failed_nxt;
        bslot_r  <= bslot_nxt;
        nslot_r  <= nslot_nxt;
      end
      if (rec_we) rvld_r[rec_wa] <= 1'b1;
      lw_rec_en_r <= rec_we;
      lw_st_en_r  <= st_we;
    end
  end

  always_ff @(posedge clk) begin
    lw_rec_a_r <= rec_wa;
    lw_rec_d_r <= rec_wd;
    lw_st_a_r  <= st_wa;
    lw_st_d_r  <= e_r.now_us;
    if (load) e_r <= q_item;
    if (fire) begin
      o_act_r  <= act;
      o_seq_r  <= seq_o;
      o_slot_r <= 6'(slot_o);
      o_base_r <= base_nxt;
      o_rto_r  <= rto_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (load)      e_vld_r <= 1'b1;
      else if (fire) e_vld_r <= 1'b0;
      if (fire)            out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = o_act_r;
  assign out_tdata  = {2'b00, o_rto_r, o_base_r, o_slot_r, o_seq_r};

  `SWSE_ASSERT_NEXT(a_fail_sticky, failed_r && !cfg.reload, failed_r)
  `SWSE_ASSERT(a_window_span, (nseq_r - base_r) <= 32'(WINDOW_DEPTH))
  `SWSE_ASSERT_NEXT(a_send_adv, fire && !cfg.reload && act == swse_pkg::ACT_SEND, nseq_r == $past(nseq_r) + 32'd1)

endmodule

@@ rtl/core/sliding_window_sender_engine_core.sv @@
// ----------------------------------------------------------------------------
// sliding_window_sender_engine_core
// Sliding-window sender control with integer RTT estimation and timers.
// ----------------------------------------------------------------------------
//  port group | dir     | contents
//  in_*       | slave   | event: tuser mode, tdata now_us/ack_seq/recv_window
//  out_*      | master  | result: tuser action, tdata seq/slot/send_base/timeout_us
//  cfg_*      | APB     | start_seq, initial_rtt_us, initial_recv_window, max_retries
//
//  One event per clock sustained while out_tready does not stall; an accepted event
//  passes queue write, slot memory read into execute and output register.
//  The execute stage updates all sender state for each event.
//  rst_n is synchronous; register defaults load the window state at once.
//  A four-entry queue lets intake continue while the output is stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_sender_engine_core #(
  parameter int WINDOW_DEPTH = swse_pkg::WINDOW_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,      // [1:0] mode
  input  logic [87:0]  in_tdata,      // [31:0] now_us, [63:32] ack_seq, [83:64] recv_window
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [2:0]   out_tuser,     // [2:0] action
  output logic [103:0] out_tdata,     // [31:0] seq, [37:32] slot, [69:38] send_base,
                                      // [101:70] timeout_us
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [31:0] start_r;
  logic [23:0] rtt_r;
  logic [19:0] rwin_r;
  logic [7:0]  retry_r;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  swse_pkg::cfg_load_t cfg_ld;
  swse_pkg::q_item_t   q_item;
  logic        q_valid, q_pop;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= swse_pkg::START_SEQ_DEF;
      rtt_r   <= swse_pkg::INIT_RTT_DEF;
      rwin_r  <= swse_pkg::INIT_RWIN_DEF;
      retry_r <= swse_pkg::MAX_RETRY_DEF;
    end else if (cfg_we) begin
      case (cfg_idx)
        swse_pkg::REG_START_SEQ: start_r <= cfg_pwdata;
        swse_pkg::REG_INIT_RTT:  rtt_r   <= cfg_pwdata[23:0];
        swse_pkg::REG_INIT_RWIN: rwin_r  <= cfg_pwdata[19:0];
        swse_pkg::REG_MAX_RETRY: retry_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      swse_pkg::REG_START_SEQ: cfg_prdata = start_r;
      swse_pkg::REG_INIT_RTT:  cfg_prdata = 32'(rtt_r);
      swse_pkg::REG_INIT_RWIN: cfg_prdata = 32'(rwin_r);
      swse_pkg::REG_MAX_RETRY: cfg_prdata = 32'(retry_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // state reloads from the value being written this cycle
  always_comb begin
    cfg_ld.reload    = cfg_we && (cfg_idx != swse_pkg::REG_MAX_RETRY);
    cfg_ld.start_seq = (cfg_idx == swse_pkg::REG_START_SEQ) ? cfg_pwdata : start_r;
    cfg_ld.init_rtt  = (cfg_idx == swse_pkg::REG_INIT_RTT)  ? cfg_pwdata[23:0] : rtt_r;
    cfg_ld.init_rwin = (cfg_idx == swse_pkg::REG_INIT_RWIN) ? cfg_pwdata[19:0] : rwin_r;
  end

  swse_front #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  swse_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_ld),
    .max_retries (retry_r),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tuser   (out_tuser),
    .out_tdata   (out_tdata)
  );

endmodule

@@ sim/swse_scoreboard.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swse_scoreboard
// Watches the event, result and register ports of the sender engine, keeps
// its own copy of the window, timer and RTT state, and checks every result.
// ----------------------------------------------------------------------------
module swse_scoreboard (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [1:0]   in_tuser,
  input  logic [87:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [2:0]   out_tuser,
  input  logic [103:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic         cfg_pready,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output int           err_cnt,
  output int           pending,
  output logic [31:0]  hint_base,
  output logic [31:0]  hint_next,
  output logic [31:0]  hint_rto
);

  typedef struct packed {
    swse_pkg::action_t action;
    logic [31:0] seq;
    logic [5:0]  slot;
    logic [31:0] base;
    logic [31:0] rto;
  } tx_result_t;

  tx_result_t exp_q[$];

  logic [31:0] r_start, r_rtt, r_rwin, r_retries;
  logic [31:0] base, nxt, credit, est, dev, rto, expiry;
  logic        dead;
  logic [31:0] sent_at[64];
  logic        retx[64];
  logic [7:0]  retries[64];
  logic        fast[64];

  assign pending   = exp_q.size();
  assign hint_base = base;
  assign hint_next = nxt;
  assign hint_rto  = rto;

  function automatic logic [31:0] cap_win(logic [31:0] w);
    return (w < 64) ? w : 32'd64;
  endfunction

  function automatic logic ahead(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return !d[31] && d != 0;
  endfunction

  task automatic reload_window();
    logic [63:0] t2;
    t2 = {31'd0, r_rtt, 1'b0};
    base   = r_start;
    nxt    = r_start;
    credit = r_start + cap_win(r_rwin);
    est    = r_rtt;
    dev    = 0;
    rto    = (t2 > swse_pkg::MIN_RTO_US) ? t2[31:0] : swse_pkg::MIN_RTO_US;
    expiry = 0;
    dead   = 0;
    for (int i = 0; i < 64; i++) begin
      sent_at[i] = 0;
      retx[i]    = 0;
      retries[i] = 0;
      fast[i]    = 0;
    end
  endtask

  // est' = (7est+s)/8, dev' = (3dev+|s-est'|)/4, rto = est'+4*max(dev',10ms)
  task automatic rtt_fold(logic [31:0] sample);
    logic [63:0] e, df, dv, t;
    e  = (64'd7 * est + sample) >> 3;
    df = (sample > e) ? sample - e : e - sample;
    dv = (64'd3 * dev + df) >> 2;
    t  = e + 64'd4 * ((dv > swse_pkg::MIN_DEV_US) ? dv : swse_pkg::MIN_DEV_US);
    est = e[31:0];
    dev = (dv > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dv[31:0];
    rto = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
  endtask

  task automatic handle_event(logic [1:0] mode, logic [31:0] now, logic [31:0] ack,
                              logic [19:0] rwin);
    tx_result_t r;
    logic       busy;
    logic [5:0] s;
    logic [31:0] cand, d;
    r    = '0;
    r.action = swse_pkg::ACT_NONE;
    busy = (base != nxt);
    if (dead) begin
      r.action = swse_pkg::ACT_FAIL;
    end else if (mode == swse_pkg::MODE_QUEUE) begin
      if (ahead(credit, nxt)) begin
        s = nxt[5:0];
        sent_at[s] = now;
        retx[s]    = 0;
        retries[s] = 0;
        fast[s]    = 0;
        if (!busy) expiry = now + rto;
        r.action = swse_pkg::ACT_SEND;
        r.seq    = nxt;
        r.slot   = s;
        nxt++;
      end else begin
        r.action = swse_pkg::ACT_REFUSE;
      end
    end else if (mode == swse_pkg::MODE_ACK) begin
      if (ack == base) begin
        if (busy && retries[base[5:0]] != 8'hFF) retries[base[5:0]]++;
      end else if (ack - base <= nxt - base) begin
        if (!retx[base[5:0]]) begin
          d = now - sent_at[(ack - 32'd1) & 32'h3F];
          rtt_fold(d[31] ? 32'd0 : d);
        end
        expiry = now + rto;
        base   = ack;
      end
      cand = base + cap_win({12'd0, rwin});
      if (ahead(cand, credit)) credit = cand;
      s = base[5:0];
      if (base != nxt && retries[s] == swse_pkg::FAST_COUNT && !fast[s]) begin
        retx[s]    = 1;
        fast[s]    = 1;
        expiry     = now + rto;
        sent_at[s] = now;
        r.action = swse_pkg::ACT_FAST;
        r.seq    = base;
        r.slot   = s;
      end
    end else if (mode == swse_pkg::MODE_TICK) begin
      d = now - expiry;
      if (busy && !d[31]) begin
        s = base[5:0];
        if ({24'd0, retries[s]} >= r_retries) begin
          dead     = 1;
          r.action = swse_pkg::ACT_FAIL;
        end else begin
          fast[s]    = 0;
          expiry     = now + rto;
          sent_at[s] = now;
          retx[s]    = 1;
          if (retries[s] != 8'hFF) retries[s]++;
          r.action = swse_pkg::ACT_TIMEOUT;
          r.seq    = base;
          r.slot   = s;
        end
      end
    end
    r.base = base;
    r.rto  = rto;
    exp_q.push_back(r);
  endtask

  task automatic compare_result();
    tx_result_t e;
    if (exp_q.size() == 0) begin
      $error("result transaction with nothing expected");
      err_cnt++;
      return;
    end
    e = exp_q.pop_front();
    if (out_tuser != e.action) begin
      $error("action exp %0d got %0d", e.action, out_tuser); err_cnt++;
    end
    if (out_tdata[31:0] != e.seq) begin
      $error("seq exp %h got %h", e.seq, out_tdata[31:0]); err_cnt++;
    end
    if (out_tdata[37:32] != e.slot) begin
      $error("slot exp %0d got %0d", e.slot, out_tdata[37:32]); err_cnt++;
    end
    if (out_tdata[69:38] != e.base) begin
      $error("send_base exp %h got %h", e.base, out_tdata[69:38]); err_cnt++;
    end
    if (out_tdata[101:70] != e.rto) begin
      $error("timeout_us exp %0d got %0d", e.rto, out_tdata[101:70]); err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      err_cnt   = 0;
      r_start   = swse_pkg::START_SEQ_DEF;
      r_rtt     = swse_pkg::INIT_RTT_DEF;
      r_rwin    = swse_pkg::INIT_RWIN_DEF;
      r_retries = swse_pkg::MAX_RETRY_DEF;
      reload_window();
      exp_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          swse_pkg::REG_START_SEQ: begin r_start = cfg_pwdata; reload_window(); end
          swse_pkg::REG_INIT_RTT: begin
            r_rtt = {8'd0, cfg_pwdata[23:0]}; reload_window();
          end
          swse_pkg::REG_INIT_RWIN: begin
            r_rwin = {12'd0, cfg_pwdata[19:0]}; reload_window();
          end
          swse_pkg::REG_MAX_RETRY: r_retries = {24'd0, cfg_pwdata[7:0]};
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) compare_result();
      if (in_tvalid && in_tready)
        handle_event(in_tuser, in_tdata[31:0], in_tdata[63:32], in_tdata[83:64]);
    end
  end

endmodule

@@ sim/sliding_window_sender_engine_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_sender_engine_core_tb
// Directed and random event streams (queue, ACK, tick) over several register
// settings and handshake idling mixes; the scoreboard checks every result.
// ----------------------------------------------------------------------------
module sliding_window_sender_engine_core_tb;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid, in_tready;
  logic [1:0]   in_tuser;
  logic [87:0]  in_tdata;
  logic         out_tvalid, out_tready;
  logic [2:0]   out_tuser;
  logic [103:0] out_tdata;
  logic         cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata, cfg_prdata;

  int           err_cnt, pending;
  logic [31:0]  hint_base, hint_next, hint_rto;
  int           send_idle_pct, recv_stall_pct;
  int           hold_req, hold_seen, hold_left;
  int           quiet_cycles;
  logic [31:0]  now;

  sliding_window_sender_engine_core dut (.*);

  swse_scoreboard u_scoreboard (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
      hold_left  <= 0;
      hold_seen  <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= 300;
      out_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("sliding_window_sender_engine_core verification failed");
      $finish;
    end
  end

  task automatic put(logic [1:0] mode, logic [31:0] t, logic [31:0] ack, logic [19:0] rwin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= mode;
    in_tdata  <= {4'd0, rwin, ack, t};
    @(posedge clk iff in_tready);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    cfg_psel    <= 1;
    cfg_pwrite  <= 1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel    <= 0;
    cfg_penable <= 0;
    cfg_pwrite  <= 0;
    @(posedge clk);
  endtask

  // wait for every expected result, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_events(int count);
    int          pick;
    logic [31:0] ack, span;
    logic [19:0] rwin;
    repeat (count) begin
      pick = $urandom_range(99);
      now  = now + $urandom_range(0, 50000);
      rwin = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 80));
      span = hint_next - hint_base;
      if (pick < 40) begin
        put(swse_pkg::MODE_QUEUE, now, $urandom, rwin);
      end else if (pick < 75) begin
        if ($urandom_range(99) < 30 || span == 0) ack = hint_base;
        else if ($urandom_range(99) < 85) ack = hint_base + $urandom_range(1, span);
        else ack = $urandom;
        put(swse_pkg::MODE_ACK, now, ack, rwin);
      end else if (pick < 90) begin
        if ($urandom_range(1)) now = now + hint_rto;
        put(swse_pkg::MODE_TICK, now, $urandom, rwin);
      end else if (pick < 95) begin
        put(2'd3, now, $urandom, rwin);
      end else begin
        put(2'($urandom), $urandom, $urandom, 20'($urandom));
      end
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0; in_tuser = 0; in_tdata = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_req = 0;
    now = 32'd10_000_000;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: sends, fast retransmit on the fourth duplicate, window moves
    put(swse_pkg::MODE_QUEUE, 1000, 0, 0);
    put(swse_pkg::MODE_QUEUE, 2000, 0, 0);
    put(swse_pkg::MODE_QUEUE, 3000, 0, 0);
    repeat (4) put(swse_pkg::MODE_ACK, 4000, 0, 64);
    put(swse_pkg::MODE_ACK, 50000, 1, 20'hFFFFF);     // base was retransmitted: no sample
    put(swse_pkg::MODE_ACK, 60000, 2, 64);            // clean sample
    put(swse_pkg::MODE_ACK, 61000, 100, 64);          // beyond next_seq
    put(swse_pkg::MODE_ACK, 62000, 0, 0);             // older than base
    put(swse_pkg::MODE_TICK, 70000, 0, 0);            // before expiry
    put(swse_pkg::MODE_TICK, 5_070_000, 0, 0);        // timeout retransmit
    put(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF);
    put(swse_pkg::MODE_QUEUE, 9_000_000, 0, 0);
    put(swse_pkg::MODE_ACK, 100, 4, 64);              // base was retransmitted: no sample
    drain();
    reg_write(swse_pkg::REG_MAX_RETRY, 1);
    put(swse_pkg::MODE_QUEUE, 1000, 0, 0);
    put(swse_pkg::MODE_TICK, 90_000_000, 0, 0);
    put(swse_pkg::MODE_TICK, 190_000_000, 0, 0);      // retry limit: give up
    put(swse_pkg::MODE_QUEUE, 0, 0, 0);               // failed answers every event
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          reg_write(swse_pkg::REG_START_SEQ, 32'hFFFF_FFF0);
          reg_write(swse_pkg::REG_INIT_RTT, 32'h00FF_FFFF);
          reg_write(swse_pkg::REG_INIT_RWIN, 32'h000F_FFFF);
          reg_write(swse_pkg::REG_MAX_RETRY, 255);
        end
        1: begin
          reg_write(swse_pkg::REG_START_SEQ, 32'h1234_5678);
          reg_write(swse_pkg::REG_INIT_RTT, 0);
          reg_write(swse_pkg::REG_INIT_RWIN, 0);
          reg_write(swse_pkg::REG_MAX_RETRY, 1);
        end
        2: begin
          reg_write(swse_pkg::REG_START_SEQ, 32'h8000_0000);
          reg_write(swse_pkg::REG_INIT_RTT, 500000);
          reg_write(swse_pkg::REG_INIT_RWIN, 16);
          reg_write(swse_pkg::REG_MAX_RETRY, 3);
        end
        3: begin
          reg_write(swse_pkg::REG_START_SEQ, 32'h7FFF_FFF0);
          reg_write(swse_pkg::REG_INIT_RTT, 1234);
          reg_write(swse_pkg::REG_INIT_RWIN, 64);
          reg_write(swse_pkg::REG_MAX_RETRY, 8);
        end
        4: begin
          reg_write(swse_pkg::REG_START_SEQ, 0);
          reg_write(swse_pkg::REG_INIT_RTT, 100000);
          reg_write(swse_pkg::REG_INIT_RWIN, 40);
          reg_write(swse_pkg::REG_MAX_RETRY, 50);
        end
        default: reg_write(swse_pkg::REG_INIT_RWIN, 64);
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      if (ph == 0) hold_req = hold_req + 1;  // long output hold while input keeps coming
      random_events(64);
      drain();
    end

    if (err_cnt == 0)
      $display("sliding_window_sender_engine_core verification clean");
    else
      $display("sliding_window_sender_engine_core verification failed");
    $finish;
  end

endmodule
